// ===== rtl/core/gtsp_pkg.sv =====
// Shared types and constants of the generation-tagged slot pool.
`default_nettype none

package gtsp_pkg;

    localparam int NUM_SLOTS = 3;
    localparam int ACT_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int GEN_W     = 64;

    // Beat payload sizes: tdata rounded up to whole bytes, tuser exact
    localparam int S_TDATA_W = ((SLOT_W + GEN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + GEN_W + 7) / 8) * 8;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TUSER_W = 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_BEGIN    = 2'd0,
        ACT_SUBMIT   = 2'd1,
        ACT_CANCEL   = 2'd2,
        ACT_COMPLETE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_AVAILABLE = 2'd0,
        PH_RECORDING = 2'd1,
        PH_SUBMITTED = 2'd2
    } phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/generation_tagged_slot_pool_unit.sv =====
// Top level of the generation-tagged slot pool: request register, slot state, result register.
// A request beat passes 2 register stages, the request register and then the result register.
// Throughput: one request beat per cycle unless results stall; each register holds one beat.
// The rate is set by the combinational slot update (priority pick, 64-bit compare and increment).
// Reset (aresetn low, synchronous) empties both registers, marks every slot available
// and clears every generation count to zero.
`default_nettype none

module generation_tagged_slot_pool_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [gtsp_pkg::S_TDATA_W-1:0] s_tdata,  // token_slot, token_generation, zero pad
    input  wire logic [gtsp_pkg::S_TUSER_W-1:0] s_tuser,  // action
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [gtsp_pkg::M_TDATA_W-1:0]     m_tdata,   // granted_slot, granted_generation, zero pad
    output logic [gtsp_pkg::M_TUSER_W-1:0]     m_tuser    // success
);
    import gtsp_pkg::*;

    // request register
    logic                 in_valid_reg;
    action_t              in_action_reg;
    logic [SLOT_W-1:0]    in_slot_reg;
    logic [GEN_W-1:0]     in_gen_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_success_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [GEN_W-1:0]     out_gen_reg;

    // slot state
    phase_t               phase_reg  [NUM_SLOTS];
    logic [GEN_W-1:0]     gen_reg    [NUM_SLOTS];
    phase_t               phase_next [NUM_SLOTS];
    logic [GEN_W-1:0]     gen_next   [NUM_SLOTS];

    logic                 advance;
    logic                 is_begin;
    phase_t               need_phase;
    phase_t               target_phase;
    logic [NUM_SLOTS-1:0] eligible;
    logic [NUM_SLOTS-1:0] grant_oh;
    logic [NUM_SLOTS-1:0] match;
    logic                 found;
    logic [SLOT_W-1:0]    grant_slot;
    logic [GEN_W-1:0]     grant_gen_old;
    logic [GEN_W-1:0]     grant_gen_new;
    logic                 ok;

    // The request in the register moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_success_reg;
    assign m_tdata  = {{(M_TDATA_W - SLOT_W - GEN_W){1'b0}}, out_gen_reg, out_slot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= action_t'(s_tuser[ACT_W-1:0]);
            in_slot_reg   <= s_tdata[SLOT_W-1:0];
            in_gen_reg    <= s_tdata[SLOT_W+GEN_W-1:SLOT_W];
        end
    end

    // Required and resulting phase of a token move
    assign is_begin = (in_action_reg == ACT_BEGIN);

    always_comb begin
        unique case (in_action_reg)
            ACT_SUBMIT: begin
                need_phase   = PH_RECORDING;
                target_phase = PH_SUBMITTED;
            end
            ACT_CANCEL: begin
                need_phase   = PH_RECORDING;
                target_phase = PH_AVAILABLE;
            end
            ACT_COMPLETE: begin
                need_phase   = PH_SUBMITTED;
                target_phase = PH_AVAILABLE;
            end
            default: begin
                need_phase   = PH_AVAILABLE;
                target_phase = PH_RECORDING;
            end
        endcase
    end

    // Slot qualification: free slots for begin, token match for the others.
    // A slot whose generation is all ones is never granted, so the count never wraps.
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            eligible[k] = (phase_reg[k] == PH_AVAILABLE) && !(&gen_reg[k]);
            match[k]    = (in_slot_reg == SLOT_W'(k)) && (gen_reg[k] == in_gen_reg)
                          && (phase_reg[k] == need_phase);
        end
    end

    // Lowest-numbered eligible slot wins
    always_comb begin
        found         = 1'b0;
        grant_oh      = '0;
        grant_slot    = '0;
        grant_gen_old = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (eligible[k] && !found) begin
                found         = 1'b1;
                grant_oh[k]   = 1'b1;
                grant_slot    = SLOT_W'(k);
                grant_gen_old = gen_reg[k];
            end
        end
    end

    assign grant_gen_new = grant_gen_old + GEN_W'(1);
    assign ok            = is_begin ? found : (|match);

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            phase_next[k] = phase_reg[k];
            gen_next[k]   = gen_reg[k];
            if (is_begin && grant_oh[k]) begin
                phase_next[k] = PH_RECORDING;
                gen_next[k]   = grant_gen_new;
            end else if (!is_begin && match[k]) begin
                phase_next[k] = target_phase;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                phase_reg[k] <= PH_AVAILABLE;
                gen_reg[k]   <= '0;
            end
        end else if (advance) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                phase_reg[k] <= phase_next[k];
                gen_reg[k]   <= gen_next[k];
            end
        end
    end

    // Result register: hold while the result beat is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Drop the grant fields on anything but a successful begin
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_success_reg <= ok;
            out_slot_reg    <= (is_begin && found) ? grant_slot : '0;
            out_gen_reg     <= (is_begin && found) ? grant_gen_new : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gtsp_checker.sv =====
// Port-level checks of the slot pool, bound to its top level.
`default_nettype none

module gtsp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [gtsp_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [gtsp_pkg::M_TUSER_W-1:0] m_tuser
);
    import gtsp_pkg::*;

    // Result register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // A failed request carries no grant
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("failed result carries grant fields");

    // A nonzero generation only comes with a successful grant of a real slot
    a_grant_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[SLOT_W+GEN_W-1:SLOT_W] != '0))
        |-> (m_tuser[0] && (m_tdata[SLOT_W-1:0] < SLOT_W'(NUM_SLOTS))))
        else $error("grant of an out-of-range slot or without success");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    // The request side takes a beat whenever the result side is free or draining
    a_take_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("request side stalled with the result side free");

endmodule

bind generation_tagged_slot_pool_unit gtsp_checker u_gtsp_checker (.*);

`default_nettype wire
